>>> design/slru_pkg.sv
package slru_pkg;

  localparam int unsigned Slots = 64;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam int unsigned LinkW = $clog2(Slots + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(Slots);
  localparam int unsigned CapW = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_HIT    = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [5:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [5:0] victim_slot;
    logic       victim_valid;
    logic       segmented;
    logic       error;
  } out_item_t;

endpackage

>>> design/slru_ram.sv
module slru_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> design/segmented_lru_replacement.sv
// Channel  Dir  Handshake                  Payload
// in       in   in_valid_i / in_ready_o    in_data_i   (operation, slot)
// out      out  out_valid_o / out_ready_i  out_data_o  (victim_slot, victim_valid,
//                                                       segmented, error)
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_data_i  (capacity)
//
// One item at a time; how long each operation takes is set by the single-port prev, next
// and mark memories.
// The insert that reaches capacity also walks the list to split it into segments.
// Reset clears pointers, counts and resident bits; link memories need no clearing pass.
// A result waits in the output register; the next item is accepted meanwhile.
module segmented_lru_replacement (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  slru_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slru_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [6:0]          cfg_data_i
);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_ST_W  = 19'h00002,
    S_RD    = 19'h00004,
    S_UNLK  = 19'h00008,
    S_PH1   = 19'h00010,
    S_PH2   = 19'h00020,
    S_HB1   = 19'h00040,
    S_HB2   = 19'h00080,
    S_HB3   = 19'h00100,
    S_PB_RD = 19'h00200,
    S_PB_W1 = 19'h00400,
    S_PB_W2 = 19'h00800,
    S_PT_W1 = 19'h01000,
    S_PT_W2 = 19'h02000,
    S_SP1   = 19'h04000,
    S_SP1W  = 19'h08000,
    S_SP2   = 19'h10000,
    S_SP2W  = 19'h20000,
    S_FIN   = 19'h40000
  } state_e;

  localparam int unsigned LW = slru_pkg::LinkW;
  localparam int unsigned SW = slru_pkg::SlotW;
  localparam logic [LW-1:0] NIL = slru_pkg::NilLink;

  state_e state_q, state_d;
  logic [1:0] op_q, op_d;
  logic [SW-1:0] slot_q, slot_d;
  logic err_q, err_d;
  logic sec_q, sec_d;
  logic [LW-1:0] head_q, head_d, tail_q, tail_d, bnd_q, bnd_d;
  logic [LW-1:0] p_q, p_d, iter_q, iter_d;
  logic [6:0] count_q, count_d;
  logic full_q, full_d;
  logic [6:0] cap_q;
  logic [5:0] third_q, cnt_q, cnt_d;
  logic [slru_pkg::Slots-1:0] res_q, res_d;
  logic out_valid_q, out_valid_d;
  slru_pkg::out_item_t out_q, out_d;
  logic [12:0] third_prod;

  logic prev_we, next_we, mark_we;
  logic [SW-1:0] prev_addr, next_addr, mark_addr;
  logic [LW-1:0] prev_wdata, next_wdata, prev_rdata, next_rdata;
  logic mark_wdata, mark_rdata;
  logic [LW-1:0] slot_ext, in_slot_ext;

  slru_ram #(.Width(LW), .Depth(slru_pkg::Slots)) u_prev (
    .clk_i, .we_i(prev_we), .addr_i(prev_addr), .wdata_i(prev_wdata), .rdata_o(prev_rdata)
  );
  slru_ram #(.Width(LW), .Depth(slru_pkg::Slots)) u_next (
    .clk_i, .we_i(next_we), .addr_i(next_addr), .wdata_i(next_wdata), .rdata_o(next_rdata)
  );
  slru_ram #(.Width(1), .Depth(slru_pkg::Slots)) u_mark (
    .clk_i, .we_i(mark_we), .addr_i(mark_addr), .wdata_i(mark_wdata), .rdata_o(mark_rdata)
  );

  assign slot_ext    = LW'(slot_q);
  assign in_slot_ext = LW'(in_data_i.slot);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign third_prod  = 13'(cfg_data_i) * 13'd43;

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    slot_d = slot_q;
    err_d = err_q;
    sec_d = sec_q;
    head_d = head_q;
    tail_d = tail_q;
    bnd_d = bnd_q;
    p_d = p_q;
    iter_d = iter_q;
    count_d = count_q;
    full_d = full_q;
    cnt_d = cnt_q;
    res_d = res_q;
    out_valid_d = out_valid_q;
    out_d = out_q;
    prev_we = 1'b0;
    next_we = 1'b0;
    mark_we = 1'b0;
    prev_addr = slot_q;
    next_addr = slot_q;
    mark_addr = slot_q;
    prev_wdata = NIL;
    next_wdata = NIL;
    mark_wdata = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i.operation;
          slot_d = in_data_i.slot;
          err_d = 1'b0;
          state_d = S_FIN;
          case (in_data_i.operation)
            slru_pkg::OP_START: begin
              res_d = '0;
              res_d[in_data_i.slot] = 1'b1;
              head_d = in_slot_ext;
              tail_d = in_slot_ext;
              bnd_d = NIL;
              count_d = 7'd1;
              full_d = 1'b0;
              state_d = S_ST_W;
            end
            slru_pkg::OP_INSERT: begin
              if (res_q[in_data_i.slot]) begin
                err_d = 1'b1;
              end else begin
                res_d[in_data_i.slot] = 1'b1;
                count_d = count_q + 7'd1;
                if (full_q) begin
                  state_d = (bnd_q == NIL) ? S_PT_W1 : S_PB_RD;
                end else begin
                  state_d = S_PH1;
                end
              end
            end
            slru_pkg::OP_REMOVE: begin
              if (!full_q || !res_q[in_data_i.slot]) begin
                err_d = 1'b1;
              end else if (in_slot_ext == bnd_q && in_slot_ext == tail_q) begin
                err_d = 1'b1;
              end else begin
                res_d[in_data_i.slot] = 1'b0;
                count_d = count_q - 7'd1;
                state_d = S_RD;
              end
            end
            default: begin
              if (!full_q) begin
                err_d = 1'b1;
              end else if (res_q[in_data_i.slot] && in_slot_ext != head_q) begin
                state_d = S_RD;
              end
            end
          endcase
        end
      end
      S_ST_W: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        state_d = S_FIN;
      end
      S_RD: begin
        state_d = S_UNLK;
      end
      S_UNLK: begin
        sec_d = mark_rdata;
        if (prev_rdata != NIL) begin
          next_we = 1'b1;
          next_addr = prev_rdata[SW-1:0];
          next_wdata = next_rdata;
        end else begin
          head_d = next_rdata;
        end
        if (next_rdata != NIL) begin
          prev_we = 1'b1;
          prev_addr = next_rdata[SW-1:0];
          prev_wdata = prev_rdata;
        end else begin
          tail_d = prev_rdata;
        end
        if (bnd_q == slot_ext) begin
          bnd_d = next_rdata;
        end
        state_d = (op_q == slru_pkg::OP_REMOVE) ? S_FIN : S_PH1;
      end
      S_PH1: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        next_wdata = head_q;
        if (op_q == slru_pkg::OP_HIT && sec_q) begin
          mark_we = 1'b1;
        end
        state_d = S_PH2;
      end
      S_PH2: begin
        if (head_q != NIL) begin
          prev_we = 1'b1;
          prev_addr = head_q[SW-1:0];
          prev_wdata = slot_ext;
        end else begin
          tail_d = slot_ext;
        end
        head_d = slot_ext;
        state_d = S_FIN;
        if (op_q == slru_pkg::OP_INSERT) begin
          if (count_q == cap_q) begin
            full_d = 1'b1;
            iter_d = slot_ext;
            cnt_d = '0;
            state_d = S_SP1;
          end
        end else if (sec_q) begin
          state_d = S_HB1;
        end
      end
      S_HB1: begin
        if (bnd_q == NIL) begin
          bnd_d = tail_q;
          state_d = S_HB3;
        end else begin
          prev_addr = bnd_q[SW-1:0];
          state_d = S_HB2;
        end
      end
      S_HB2: begin
        if (prev_rdata != NIL) begin
          bnd_d = prev_rdata;
        end
        state_d = S_HB3;
      end
      S_HB3: begin
        if (bnd_q != NIL) begin
          mark_we = 1'b1;
          mark_addr = bnd_q[SW-1:0];
          mark_wdata = 1'b1;
        end
        state_d = S_FIN;
      end
      S_PB_RD: begin
        prev_addr = bnd_q[SW-1:0];
        state_d = S_PB_W1;
      end
      S_PB_W1: begin
        p_d = prev_rdata;
        prev_we = 1'b1;
        prev_wdata = prev_rdata;
        next_we = 1'b1;
        next_wdata = bnd_q;
        mark_we = 1'b1;
        mark_wdata = 1'b1;
        state_d = S_PB_W2;
      end
      S_PB_W2: begin
        prev_we = 1'b1;
        prev_addr = bnd_q[SW-1:0];
        prev_wdata = slot_ext;
        if (p_q != NIL) begin
          next_we = 1'b1;
          next_addr = p_q[SW-1:0];
          next_wdata = slot_ext;
        end else begin
          head_d = slot_ext;
        end
        bnd_d = slot_ext;
        state_d = S_FIN;
      end
      S_PT_W1: begin
        prev_we = 1'b1;
        prev_wdata = tail_q;
        next_we = 1'b1;
        mark_we = 1'b1;
        mark_wdata = 1'b1;
        state_d = S_PT_W2;
      end
      S_PT_W2: begin
        if (tail_q != NIL) begin
          next_we = 1'b1;
          next_addr = tail_q[SW-1:0];
          next_wdata = slot_ext;
        end else begin
          head_d = slot_ext;
        end
        tail_d = slot_ext;
        bnd_d = slot_ext;
        state_d = S_FIN;
      end
      S_SP1: begin
        if (cnt_q < third_q && iter_q != NIL) begin
          mark_we = 1'b1;
          mark_addr = iter_q[SW-1:0];
          next_addr = iter_q[SW-1:0];
          state_d = S_SP1W;
        end else begin
          bnd_d = iter_q;
          state_d = S_SP2;
        end
      end
      S_SP1W: begin
        iter_d = next_rdata;
        cnt_d = cnt_q + 6'd1;
        state_d = S_SP1;
      end
      S_SP2: begin
        if (iter_q != NIL) begin
          mark_we = 1'b1;
          mark_addr = iter_q[SW-1:0];
          mark_wdata = 1'b1;
          next_addr = iter_q[SW-1:0];
          state_d = S_SP2W;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SP2W: begin
        iter_d = next_rdata;
        state_d = S_SP2;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.victim_valid = (tail_q != NIL);
          out_d.victim_slot = (tail_q != NIL) ? tail_q[5:0] : 6'd0;
          out_d.segmented = full_q;
          out_d.error = err_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= NIL;
      tail_q <= NIL;
      bnd_q <= NIL;
      count_q <= '0;
      full_q <= 1'b0;
      res_q <= '0;
      out_valid_q <= 1'b0;
      cap_q <= slru_pkg::CapReset;
      third_q <= 6'd21;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      tail_q <= tail_d;
      bnd_q <= bnd_d;
      count_q <= count_d;
      full_q <= full_d;
      res_q <= res_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
        third_q <= third_prod[12:7];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    slot_q <= slot_d;
    err_q <= err_d;
    sec_q <= sec_d;
    p_q <= p_d;
    iter_q <= iter_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

endmodule

>>> design/slru_checker.sv
module slru_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input slru_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input slru_pkg::out_item_t out_data_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [6:0]          cfg_data_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_empty_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.victim_valid |-> out_data_o.victim_slot == 6'd0)
    else $error("victim slot nonzero on empty list");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous item in work");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind segmented_lru_replacement slru_checker u_slru_checker (.*);
